[design/i2cbm_pkg.sv]
// Shared types and constants for the I2C bus master sequencer.
package i2cbm_pkg;

  localparam int unsigned UNIT_W   = 16;
  localparam int unsigned DELAY_W  = 18;
  localparam logic [UNIT_W-1:0] UNIT_TICKS_RESET = 16'd100;
  localparam logic [7:0] ACK_POLL_LIMIT = 8'd250;
  localparam logic [7:0] TX_MSB_MASK = 8'h80;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_WACK  = 3'd4;
  localparam logic [2:0] CMD_READ  = 3'd5;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_S1,
    PH_S2,
    PH_P1,
    PH_P2,
    PH_W1,
    PH_W2,
    PH_W3,
    PH_A1,
    PH_A2,
    PH_R1,
    PH_R2,
    PH_K1,
    PH_K2
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [2:0]         bit_count;
    logic [7:0]         shift_reg;
    logic [DELAY_W-1:0] delay_count;
    logic [7:0]         poll_count;
    logic               scl;
    logic               sda;
    logic               fail;
    logic [7:0]         rx_hold;
    logic               ack_sel;
  } seq_state_t;

  localparam seq_state_t SEQ_STATE_RESET = '{
    phase:       PH_IDLE,
    bit_count:   3'd0,
    shift_reg:   8'd0,
    delay_count: '0,
    poll_count:  8'd0,
    scl:         1'b1,
    sda:         1'b1,
    fail:        1'b0,
    rx_hold:     8'd0,
    ack_sel:     1'b0
  };

endpackage

[design/i2cbm_in_if.sv]
// Input channel: one tick per beat, with an optional command.
interface i2cbm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, cmd, tx_byte, send_ack, sda_in, input ready);
  modport sink   (input valid, cmd, tx_byte, send_ack, sda_in, output ready);
endinterface

[design/i2cbm_out_if.sv]
// Result channel: bus pin levels and status after each tick.
interface i2cbm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_failed;

  modport source (output valid, scl_level, sda_release, busy_res, done_res, rx_byte,
                  ack_failed, input ready);
  modport sink   (input valid, scl_level, sda_release, busy_res, done_res, rx_byte,
                  ack_failed, output ready);
endinterface

[design/i2cbm_cfg_if.sv]
// Configuration write channel carrying the delay unit length in ticks.
interface i2cbm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] unit_ticks;

  modport source (output valid, unit_ticks, input ready);
  modport sink   (input valid, unit_ticks, output ready);
endinterface

[design/i2cbm_step.sv]
// Next-state logic of the sequencer for one tick.
module i2cbm_step (
  input  i2cbm_pkg::seq_state_t          cur,
  input  logic [i2cbm_pkg::UNIT_W-1:0]   unit_ticks,
  input  logic [2:0]                     cmd,
  input  logic [7:0]                     tx_byte,
  input  logic                           send_ack,
  input  logic                           sda_in,
  output i2cbm_pkg::seq_state_t          nxt,
  output logic                           done
);

  logic [i2cbm_pkg::UNIT_W-1:0]  u_eff;
  logic [i2cbm_pkg::DELAY_W-1:0] w1, w2, w4;
  logic [i2cbm_pkg::DELAY_W-1:0] dc_dec;
  logic [7:0]                    tx_sh;

  always_comb begin
    u_eff = (unit_ticks == '0) ? {{(i2cbm_pkg::UNIT_W-1){1'b0}}, 1'b1} : unit_ticks;
    w1 = {2'b00, u_eff};
    w2 = {1'b0, u_eff, 1'b0};
    w4 = {u_eff, 2'b00};
    dc_dec = (cur.delay_count != '0) ? cur.delay_count - 1'b1 : cur.delay_count;
    tx_sh = '0;

    nxt  = cur;
    done = 1'b0;

    if (cur.phase == i2cbm_pkg::PH_IDLE) begin
      nxt.bit_count = 3'd0;
      case (cmd)
        i2cbm_pkg::CMD_START: begin
          nxt.sda = 1'b1;
          nxt.scl = 1'b1;
          nxt.delay_count = w4;
          nxt.phase = i2cbm_pkg::PH_S1;
        end
        i2cbm_pkg::CMD_STOP: begin
          nxt.scl = 1'b0;
          nxt.sda = 1'b0;
          nxt.delay_count = w4;
          nxt.phase = i2cbm_pkg::PH_P1;
        end
        i2cbm_pkg::CMD_WRITE: begin
          // first bit goes out right away, MSB first
          nxt.scl = 1'b0;
          nxt.sda = |(tx_byte & i2cbm_pkg::TX_MSB_MASK);
          nxt.shift_reg = {tx_byte[6:0], 1'b0};
          nxt.delay_count = w2;
          nxt.phase = i2cbm_pkg::PH_W1;
        end
        i2cbm_pkg::CMD_WACK: begin
          nxt.fail = 1'b0;
          nxt.poll_count = 8'd0;
          nxt.sda = 1'b1;
          nxt.delay_count = w1;
          nxt.phase = i2cbm_pkg::PH_A1;
        end
        i2cbm_pkg::CMD_READ: begin
          nxt.shift_reg = 8'd0;
          nxt.ack_sel = send_ack;
          nxt.sda = 1'b1;
          nxt.scl = 1'b0;
          nxt.delay_count = w2;
          nxt.phase = i2cbm_pkg::PH_R1;
        end
        default: begin
          nxt.bit_count = 3'd0;
        end
      endcase
    end else begin
      nxt.delay_count = dc_dec;
      if (dc_dec == '0) begin
        case (cur.phase)
          i2cbm_pkg::PH_S1: begin
            nxt.sda = 1'b0;
            nxt.delay_count = w4;
            nxt.phase = i2cbm_pkg::PH_S2;
          end
          i2cbm_pkg::PH_S2: begin
            nxt.scl = 1'b0;
            done = 1'b1;
          end
          i2cbm_pkg::PH_P1: begin
            nxt.scl = 1'b1;
            nxt.sda = 1'b1;
            nxt.delay_count = w4;
            nxt.phase = i2cbm_pkg::PH_P2;
          end
          i2cbm_pkg::PH_P2: begin
            done = 1'b1;
          end
          i2cbm_pkg::PH_W1: begin
            nxt.scl = 1'b1;
            nxt.delay_count = w2;
            nxt.phase = i2cbm_pkg::PH_W2;
          end
          i2cbm_pkg::PH_W2: begin
            nxt.scl = 1'b0;
            nxt.delay_count = w2;
            nxt.phase = i2cbm_pkg::PH_W3;
          end
          i2cbm_pkg::PH_W3: begin
            if (cur.bit_count == 3'd7) begin
              done = 1'b1;
            end else begin
              tx_sh = cur.shift_reg;
              nxt.bit_count = cur.bit_count + 3'd1;
              nxt.sda = |(tx_sh & i2cbm_pkg::TX_MSB_MASK);
              nxt.shift_reg = {tx_sh[6:0], 1'b0};
              nxt.delay_count = w2;
              nxt.phase = i2cbm_pkg::PH_W1;
            end
          end
          i2cbm_pkg::PH_A1: begin
            nxt.scl = 1'b1;
            nxt.delay_count = w1;
            nxt.phase = i2cbm_pkg::PH_A2;
          end
          i2cbm_pkg::PH_A2: begin
            if (!sda_in) begin
              nxt.scl = 1'b0;
              nxt.fail = 1'b0;
              done = 1'b1;
            end else if (cur.poll_count >= i2cbm_pkg::ACK_POLL_LIMIT) begin
              // timed out: flag and run a full stop
              nxt.fail = 1'b1;
              nxt.scl = 1'b0;
              nxt.sda = 1'b0;
              nxt.delay_count = w4;
              nxt.phase = i2cbm_pkg::PH_P1;
            end else begin
              nxt.poll_count = cur.poll_count + 8'd1;
              nxt.delay_count = w1;
              nxt.phase = i2cbm_pkg::PH_A2;
            end
          end
          i2cbm_pkg::PH_R1: begin
            nxt.scl = 1'b1;
            nxt.shift_reg = {cur.shift_reg[6:0], sda_in};
            nxt.delay_count = w1;
            nxt.phase = i2cbm_pkg::PH_R2;
          end
          i2cbm_pkg::PH_R2: begin
            nxt.scl = 1'b0;
            nxt.delay_count = w2;
            if (cur.bit_count == 3'd7) begin
              nxt.sda = ~cur.ack_sel;
              nxt.phase = i2cbm_pkg::PH_K1;
            end else begin
              nxt.bit_count = cur.bit_count + 3'd1;
              nxt.phase = i2cbm_pkg::PH_R1;
            end
          end
          i2cbm_pkg::PH_K1: begin
            nxt.scl = 1'b1;
            nxt.delay_count = w2;
            nxt.phase = i2cbm_pkg::PH_K2;
          end
          i2cbm_pkg::PH_K2: begin
            nxt.scl = 1'b0;
            nxt.rx_hold = cur.shift_reg;
            done = 1'b1;
          end
          default: begin
            done = 1'b1;
          end
        endcase
        if (done) begin
          nxt.phase = i2cbm_pkg::PH_IDLE;
          nxt.delay_count = '0;
        end
      end
    end
  end

endmodule

[design/i2c_bus_master_sequencer_top.sv]
// Top level of the byte-level I2C bus master sequencer.
//
// Usage: every beat on in_if is one tick of the bus sequencer. While the
// sequencer is idle a beat may carry a command (start, stop, write byte,
// wait ack, read byte); commands on beats that arrive while busy are dropped.
// sda_in is the sampled SDA level for that tick. Each accepted beat yields
// exactly one beat on out_if with the SCL and SDA pin levels, busy and done
// status, the last read byte and the wait-ack failure flag.
// The result of a beat is registered and presented on out_if in the cycle
// after the beat is accepted. Throughput: one beat per cycle while out_if
// takes results; the single result register accepts a new beat in the same
// cycle its held result is taken. Stall: while out_if.ready is low and a result
// is held, in_if.ready drops and the sequencer state holds, so no tick is lost or repeated.
// cfg_if writes the delay unit length in ticks (zero acts as one); write it
// only while the sequencer is idle. cfg_if.ready is always high.
// Reset: synchronous on rst_n low; SCL and SDA released high, state idle,
// unit length 100 ticks, no result pending.
module i2c_bus_master_sequencer_top (
  input  logic          clk,
  input  logic          rst_n,
  i2cbm_in_if.sink      in_if,
  i2cbm_out_if.source   out_if,
  i2cbm_cfg_if.sink     cfg_if
);

  i2cbm_pkg::seq_state_t          st_r, st_nxt;
  logic [i2cbm_pkg::UNIT_W-1:0]   unit_ticks_r;
  logic                           out_valid_r;
  logic                           done_nxt;
  logic                           done_r;
  logic                           in_fire;

  assign in_if.ready  = ~out_valid_r | out_if.ready;
  assign in_fire      = in_if.valid & in_if.ready;
  assign cfg_if.ready = 1'b1;

  i2cbm_step u_step (
    .cur        (st_r),
    .unit_ticks (unit_ticks_r),
    .cmd        (in_if.cmd),
    .tx_byte    (in_if.tx_byte),
    .send_ack   (in_if.send_ack),
    .sda_in     (in_if.sda_in),
    .nxt        (st_nxt),
    .done       (done_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r <= i2cbm_pkg::UNIT_TICKS_RESET;
    end else if (cfg_if.valid) begin
      unit_ticks_r <= cfg_if.unit_ticks;
    end
  end

  // advance the sequencer one tick per accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= i2cbm_pkg::SEQ_STATE_RESET;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r   <= st_nxt;
        done_r <= done_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.scl_level   = st_r.scl;
  assign out_if.sda_release = st_r.sda;
  assign out_if.busy_res    = (st_r.phase != i2cbm_pkg::PH_IDLE);
  assign out_if.done_res    = done_r;
  assign out_if.rx_byte     = st_r.rx_hold;
  assign out_if.ack_failed  = st_r.fail;

endmodule
